[rtl/core/assert_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define PSV_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define PSV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`endif

[rtl/core/psieve_pkg.sv]
// Types, constants and control store for the prime sieve table.
`default_nettype none

package psieve_pkg;

  localparam int VAL_W     = 12;         // limit and prime value width
  localparam int IDX_W     = 10;         // read index width
  localparam int CNT_OUT_W = 11;         // prime count width on the result
  localparam int EXT_W     = VAL_W + 1;  // room for sums that pass the limit
  localparam int STEP_W    = 4;

  localparam logic OPER_BUILD = 1'b0;
  localparam logic OPER_READ  = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [VAL_W-1:0] limit;
    logic [IDX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0]     prime_value;
    logic [CNT_OUT_W-1:0] prime_count;
    logic                 index_valid;
  } rsp_t;

  typedef logic [STEP_W-1:0] step_t;

  // Program addresses.
  localparam step_t S_IDLE       = 4'd0;
  localparam step_t S_DISPATCH   = 4'd1;
  localparam step_t S_CHECK      = 4'd2;
  localparam step_t S_START      = 4'd3;
  localparam step_t S_CLEAR      = 4'd4;
  localparam step_t S_D_INIT     = 4'd5;
  localparam step_t S_D_TEST     = 4'd6;
  localparam step_t S_D_CHECK    = 4'd7;
  localparam step_t S_MARK       = 4'd8;
  localparam step_t S_D_NEXT     = 4'd9;
  localparam step_t S_SCAN_INIT  = 4'd10;
  localparam step_t S_SCAN_FIRST = 4'd11;
  localparam step_t S_SCAN       = 4'd12;
  localparam step_t S_RESP       = 4'd13;
  localparam step_t S_READ       = 4'd14;
  localparam step_t S_READ_RESP  = 4'd15;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_START,
    OP_CLEAR,
    OP_D_INIT,
    OP_D_READ,
    OP_M_INIT,
    OP_MARK,
    OP_D_NEXT,
    OP_N_INIT,
    OP_SCAN_RD,
    OP_SCAN,
    OP_RESP,
    OP_LIST_RD,
    OP_RESP_READ
  } dp_op_e;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_REQ,
    COND_IS_READ,
    COND_NO_BUILD,
    COND_CLR_MORE,
    COND_SQ_OVER,
    COND_COMPOSITE,
    COND_MARK_MORE,
    COND_LIM_SMALL,
    COND_SCAN_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    dp_op_e op;
    cond_e  cond;
    step_t  target;
    logic   last;    // fall back to idle when the jump is not taken
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic is_read;
    logic build_needed;
    logic clr_more;
    logic sq_over;
    logic composite;
    logic mark_more;
    logic lim_small;
    logic scan_more;
    logic out_busy;
  } status_t;

  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t w;
    case (step)
      S_IDLE:       w = '{OP_CAPTURE,   COND_NO_REQ,    S_IDLE,       1'b0};
      S_DISPATCH:   w = '{OP_NOP,       COND_IS_READ,   S_READ,       1'b0};
      S_CHECK:      w = '{OP_NOP,       COND_NO_BUILD,  S_RESP,       1'b0};
      S_START:      w = '{OP_START,     COND_NEVER,     S_IDLE,       1'b0};
      S_CLEAR:      w = '{OP_CLEAR,     COND_CLR_MORE,  S_CLEAR,      1'b0};
      S_D_INIT:     w = '{OP_D_INIT,    COND_NEVER,     S_IDLE,       1'b0};
      S_D_TEST:     w = '{OP_D_READ,    COND_SQ_OVER,   S_SCAN_INIT,  1'b0};
      S_D_CHECK:    w = '{OP_M_INIT,    COND_COMPOSITE, S_D_NEXT,     1'b0};
      S_MARK:       w = '{OP_MARK,      COND_MARK_MORE, S_MARK,       1'b0};
      S_D_NEXT:     w = '{OP_D_NEXT,    COND_ALWAYS,    S_D_TEST,     1'b0};
      S_SCAN_INIT:  w = '{OP_N_INIT,    COND_LIM_SMALL, S_RESP,       1'b0};
      S_SCAN_FIRST: w = '{OP_SCAN_RD,   COND_NEVER,     S_IDLE,       1'b0};
      S_SCAN:       w = '{OP_SCAN,      COND_SCAN_MORE, S_SCAN,       1'b0};
      S_RESP:       w = '{OP_RESP,      COND_OUT_BUSY,  S_RESP,       1'b1};
      S_READ:       w = '{OP_LIST_RD,   COND_NEVER,     S_IDLE,       1'b0};
      S_READ_RESP:  w = '{OP_RESP_READ, COND_OUT_BUSY,  S_READ_RESP,  1'b1};
      default:      w = '{OP_NOP,       COND_NEVER,     S_IDLE,       1'b1};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[rtl/core/psieve_seq.sv]
// Step counter and conditional branch logic over the control store.
`default_nettype none

module psieve_seq (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  psieve_pkg::status_t stat_i,
  output psieve_pkg::ctrl_t   ctrl_o
);
  import psieve_pkg::*;

  step_t upc_q, upc_d;
  ctrl_t ctrl;
  logic  take;

  assign ctrl   = ucode_rom(upc_q);
  assign ctrl_o = ctrl;

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_REQ:    take = !stat_i.in_fire;
      COND_IS_READ:   take = stat_i.is_read;
      COND_NO_BUILD:  take = !stat_i.build_needed;
      COND_CLR_MORE:  take = stat_i.clr_more;
      COND_SQ_OVER:   take = stat_i.sq_over;
      COND_COMPOSITE: take = stat_i.composite;
      COND_MARK_MORE: take = stat_i.mark_more;
      COND_LIM_SMALL: take = stat_i.lim_small;
      COND_SCAN_MORE: take = stat_i.scan_more;
      COND_OUT_BUSY:  take = stat_i.out_busy;
      default:        take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      upc_d = ctrl.target;
    end else if (ctrl.last) begin
      upc_d = S_IDLE;
    end else begin
      upc_d = upc_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/psieve_dp.sv]
// Sieve datapath: bitmap and prime list memories, counters and result register.
`default_nettype none

module psieve_dp #(
  parameter int MAX_LIMIT   = 4095,
  parameter int PRIME_SLOTS = 1024
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  psieve_pkg::ctrl_t   ctrl_i,
  output psieve_pkg::status_t stat_o,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  psieve_pkg::req_t    in_req_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output psieve_pkg::rsp_t    out_rsp_o
);
  import psieve_pkg::*;

  localparam int MAP_AW  = $clog2(MAX_LIMIT + 1);
  localparam int SLOT_AW = $clog2(PRIME_SLOTS);
  localparam int CNT_W   = $clog2(PRIME_SLOTS + 1);

  logic             map_q [MAX_LIMIT+1];
  logic [VAL_W-1:0] list_q [PRIME_SLOTS];

  req_t             req_q;
  logic [VAL_W-1:0] lim_q;
  logic [CNT_W-1:0] cnt_q;
  logic [EXT_W-1:0] n_q;
  logic [VAL_W-1:0] d_q;
  logic [EXT_W-1:0] sq_q;
  logic [EXT_W-1:0] m_q;
  logic             map_rdata_q;
  logic [VAL_W-1:0] list_rdata_q;
  rsp_t             out_q;
  logic             out_valid_q;

  logic             in_fire;
  logic             out_busy;
  logic [VAL_W-1:0] lim_sat;
  logic [EXT_W-1:0] lim_ext;
  logic [EXT_W-1:0] mark_sum;
  logic [EXT_W-1:0] n_prev;
  logic             room;
  logic             keep_prime;
  logic             idx_ok;
  logic             map_we;
  logic [MAP_AW-1:0] map_waddr;
  logic             map_wdata;
  logic             map_re;
  logic [MAP_AW-1:0] map_raddr;
  logic             load_out;

  assign in_ready_o  = (ctrl_i.op == OP_CAPTURE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_busy    = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Requests above the bitmap saturate to its top.
  assign lim_sat  = (32'(req_q.limit) > MAX_LIMIT) ? VAL_W'(MAX_LIMIT) : req_q.limit;
  assign lim_ext  = EXT_W'(lim_q);
  assign mark_sum = m_q + EXT_W'(d_q);
  assign n_prev   = n_q - EXT_W'(1);
  assign room     = 32'(cnt_q) < PRIME_SLOTS;
  // During the scan the bitmap data belongs to the number before n_q.
  assign keep_prime = (ctrl_i.op == OP_SCAN) && !map_rdata_q && room;
  assign idx_ok   = (32'(req_q.index) < 32'(cnt_q)) && (32'(req_q.index) < PRIME_SLOTS);
  assign load_out = ((ctrl_i.op == OP_RESP) || (ctrl_i.op == OP_RESP_READ)) && !out_busy;

  always_comb begin
    stat_o.in_fire      = in_fire;
    stat_o.is_read      = (req_q.operation == OPER_READ);
    stat_o.build_needed = (cnt_q == '0) || (lim_q < lim_sat);
    stat_o.clr_more     = n_q < lim_ext;
    stat_o.sq_over      = sq_q > lim_ext;
    stat_o.composite    = map_rdata_q;
    stat_o.mark_more    = mark_sum <= lim_ext;
    stat_o.lim_small    = lim_q < VAL_W'(2);
    stat_o.scan_more    = n_q <= lim_ext;
    stat_o.out_busy     = out_busy;
  end

  always_comb begin
    map_we    = (ctrl_i.op == OP_CLEAR) || (ctrl_i.op == OP_MARK);
    map_wdata = (ctrl_i.op == OP_MARK);
    map_waddr = (ctrl_i.op == OP_MARK) ? MAP_AW'(m_q) : MAP_AW'(n_q);
    map_re    = (ctrl_i.op == OP_D_READ) || (ctrl_i.op == OP_SCAN_RD) ||
                (ctrl_i.op == OP_SCAN);
    map_raddr = (ctrl_i.op == OP_D_READ) ? MAP_AW'(d_q) : MAP_AW'(n_q);
  end

  // Composite bitmap: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_q[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rdata_q <= map_q[map_raddr];
    end
  end

  // Prime list: written in order by the scan, read by index.
  always_ff @(posedge clk_i) begin
    if (keep_prime) begin
      list_q[SLOT_AW'(cnt_q)] <= n_prev[VAL_W-1:0];
    end
    if (ctrl_i.op == OP_LIST_RD) begin
      list_rdata_q <= list_q[SLOT_AW'(req_q.index)];
    end
  end

  // Working registers of the sieve loops.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_req_i;
    end
    case (ctrl_i.op)
      OP_START:   n_q <= EXT_W'(2);
      OP_CLEAR:   n_q <= n_q + EXT_W'(1);
      OP_N_INIT:  n_q <= EXT_W'(2);
      OP_SCAN_RD: n_q <= n_q + EXT_W'(1);
      OP_SCAN:    n_q <= n_q + EXT_W'(1);
      default:    n_q <= n_q;
    endcase
    case (ctrl_i.op)
      OP_D_INIT: begin
        d_q  <= VAL_W'(2);
        sq_q <= EXT_W'(4);
      end
      OP_D_NEXT: begin
        // (d+1)^2 = d^2 + 2d + 1
        d_q  <= d_q + VAL_W'(1);
        sq_q <= sq_q + EXT_W'({d_q, 1'b1});
      end
      default: begin
        d_q  <= d_q;
        sq_q <= sq_q;
      end
    endcase
    case (ctrl_i.op)
      OP_M_INIT: m_q <= sq_q;
      OP_MARK:   m_q <= mark_sum;
      default:   m_q <= m_q;
    endcase
    if (load_out) begin
      out_q.prime_count <= CNT_OUT_W'(cnt_q);
      if (ctrl_i.op == OP_RESP_READ && idx_ok) begin
        out_q.prime_value <= list_rdata_q;
        out_q.index_valid <= 1'b1;
      end else begin
        out_q.prime_value <= '0;
        out_q.index_valid <= 1'b0;
      end
    end
  end

  // Table state and result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.op == OP_START) begin
        lim_q <= lim_sat;
        cnt_q <= '0;
      end else if (keep_prime) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/prime_sieve_table.sv]
// Top level: prime table built with a microcoded sieve of Eratosthenes.
// A read passes the dispatch and list read steps before the result register loads; a build
// that keeps the table passes the dispatch and check steps. A rebuild clears the bitmap over
// 2..limit, strikes the multiples of each candidate divisor d with d*d <= limit, then scans it.
// Requests are served one at a time; the next is taken after the result has loaded.
// Reset clears the step counter, stored limit and count (table empty); memories keep junk.
`default_nettype none

module prime_sieve_table #(
  parameter int MAX_LIMIT   = 4095,
  parameter int PRIME_SLOTS = 1024
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  psieve_pkg::req_t in_req_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output psieve_pkg::rsp_t out_rsp_o
);
  import psieve_pkg::*;

  ctrl_t   ctrl;
  status_t stat;

  psieve_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  psieve_dp #(
    .MAX_LIMIT   (MAX_LIMIT),
    .PRIME_SLOTS (PRIME_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire

[rtl/core/psieve_chk.sv]
// Port-level checker for the prime sieve table, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module psieve_chk #(
  parameter int PRIME_SLOTS = 1024
) (
  input wire              clk_i,
  input wire              rst_ni,
  input wire              in_valid_i,
  input wire              in_ready_o,
  input psieve_pkg::req_t in_req_i,
  input wire              out_valid_o,
  input wire              out_ready_i,
  input psieve_pkg::rsp_t out_rsp_o
);
  import psieve_pkg::*;

  // A result waits until it is taken.
  `PSV_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // The block works on one request at a time.
  `PSV_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // A missed read or a build reports a zero value; a hit reports a value of at least two.
  `PSV_ASSERT_IMPLY(a_miss_zero, clk_i, rst_ni, out_valid_o && !out_rsp_o.index_valid,
                    out_rsp_o.prime_value == '0)
  `PSV_ASSERT_IMPLY(a_hit_prime, clk_i, rst_ni, out_valid_o && out_rsp_o.index_valid,
                    out_rsp_o.prime_value >= VAL_W'(2))

  // The reported count never passes the list capacity.
  `PSV_ASSERT_IMPLY(a_count_cap, clk_i, rst_ni, out_valid_o,
                    32'(out_rsp_o.prime_count) <= PRIME_SLOTS)

endmodule

bind prime_sieve_table psieve_chk #(.PRIME_SLOTS(PRIME_SLOTS)) u_psieve_chk (.*);

`default_nettype wire
